[rtl/core/indexed_list_store_defines.svh]
// assertion macros used by the list store datapath
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// consequence holds at the same edge as the condition
`define ILS_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// consequence holds at the edge following the condition
`define ILS_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[rtl/core/ils_pkg.sv]
// types and constants of the indexed list store
`default_nettype none

package ils_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_APPEND = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [3:0]         position;
        logic signed [31:0] data_in;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data_out;
        logic [4:0]         length;
    } t_resp;

    typedef enum logic {
        S_EMPTY = 1'b0,
        S_HELD  = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/core/ils_ctrl.sv]
// handshake controller of the list store
`default_nettype none

module ils_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    output ils_pkg::t_cmd o_cmd
);

    ils_pkg::t_state r_state;
    ils_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ils_pkg::S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ils_pkg::S_EMPTY: begin
                if (i_in_valid) begin
                    n_state = ils_pkg::S_HELD;
                end
            end
            ils_pkg::S_HELD: begin
                if (i_out_ready && !i_in_valid) begin
                    n_state = ils_pkg::S_EMPTY;
                end
            end
            default: begin
                n_state = ils_pkg::S_EMPTY;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_out_valid = 1'b0;
        o_in_ready  = 1'b0;
        case (r_state)
            ils_pkg::S_EMPTY: begin
                o_in_ready = 1'b1;
            end
            ils_pkg::S_HELD: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load = i_in_valid && o_in_ready;
    end

endmodule

`default_nettype wire

[rtl/core/ils_datapath.sv]
// shifting entry array, length counter and result register
`default_nettype none

module ils_datapath #(
    parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  ils_pkg::t_cmd  i_cmd,
    input  ils_pkg::t_req  i_req,
    output ils_pkg::t_resp o_resp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam int LW = (CW > 5) ? CW : 5;

    logic [DATA_WIDTH-1:0] r_entries [CAPACITY];
    logic [DATA_WIDTH-1:0] n_entries [CAPACITY];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    ils_pkg::t_resp        r_resp;
    ils_pkg::t_resp        n_resp;

    logic [PW-1:0]            pos_ext;
    logic [PW-1:0]            cnt_ext;
    logic                     in_range;
    logic                     full;
    logic [DATA_WIDTH+31:0]   wide_in;
    logic [DATA_WIDTH-1:0]    store_val;
    logic [DATA_WIDTH-1:0]    rd_word;
    logic [DATA_WIDTH+31:0]   wide_out;
    logic [LW-1:0]            len_ext;

    always_comb begin
        pos_ext   = PW'(i_req.position);
        cnt_ext   = PW'(r_count);
        in_range  = pos_ext < cnt_ext;
        full      = r_count == CW'(CAPACITY);
        wide_in   = {{DATA_WIDTH{i_req.data_in[31]}}, i_req.data_in};
        store_val = wide_in[DATA_WIDTH-1:0];
        rd_word   = r_entries[pos_ext[IW-1:0]];
        wide_out  = {{32{rd_word[DATA_WIDTH-1]}}, rd_word};

        n_entries       = r_entries;
        n_count         = r_count;
        n_resp.status   = ils_pkg::ST_DONE;
        n_resp.data_out = '0;

        case (i_req.mode)
            ils_pkg::MODE_READ: begin
                if (in_range) begin
                    n_resp.data_out = wide_out[31:0];
                end else begin
                    n_resp.status = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::MODE_INSERT: begin
                if (full) begin
                    n_resp.status = ils_pkg::ST_FULL;
                end else begin
                    // each held entry moves up one place and the new value goes in at place 0
                    n_entries[0] = store_val;
                    for (int k = 1; k < CAPACITY; k++) begin
                        n_entries[k] = r_entries[k-1];
                    end
                    n_count = r_count + CW'(1);
                end
            end
            ils_pkg::MODE_APPEND: begin
                if (full) begin
                    n_resp.status = ils_pkg::ST_FULL;
                end else begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (CW'(k) == r_count) begin
                            n_entries[k] = store_val;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            ils_pkg::MODE_REMOVE: begin
                if (in_range) begin
                    n_resp.data_out = wide_out[31:0];
                    // entries at and above the position close the gap
                    for (int k = 0; k < CAPACITY - 1; k++) begin
                        if (PW'(k) >= pos_ext) begin
                            n_entries[k] = r_entries[k+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end else begin
                    n_resp.status = ils_pkg::ST_RANGE;
                end
            end
            default: begin
                n_resp.status = ils_pkg::ST_DONE;
            end
        endcase

        len_ext       = LW'(n_count);
        n_resp.length = len_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_entries <= n_entries;
            r_resp    <= n_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= n_count;
        end
    end

    assign o_resp = r_resp;

`include "indexed_list_store_defines.svh"

    `ILS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "length above capacity")
    `ILS_ASSERT_NEXT(a_read_keeps_count, i_cmd.load && i_req.mode == ils_pkg::MODE_READ, $stable(r_count), "read changed length")
    `ILS_ASSERT_NEXT(a_full_refused, i_cmd.load && full && (i_req.mode == ils_pkg::MODE_INSERT || i_req.mode == ils_pkg::MODE_APPEND), r_resp.status == ils_pkg::ST_FULL && $stable(r_count), "full list took a value")

endmodule

`default_nettype wire

[rtl/core/indexed_list_store.sv]
// top level of the indexed list store
// result: a request accepted at one edge has its result registered and valid after that edge
// throughput: one request per cycle while results are taken; the result register
//   is refilled in the same cycle it is drained
// reset: synchronous active low, empties the list and drops any held result;
//   entry storage keeps its contents and is never read until written
`default_nettype none

module indexed_list_store #(
    parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    // request channel
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  ils_pkg::t_req  i_req,
    // result channel
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output ils_pkg::t_resp o_resp
);

    // load strobe from the controller into the datapath
    ils_pkg::t_cmd cmd;

    // controller: tracks whether the result register is occupied and
    // takes a new request when it is empty or being drained this cycle
    ils_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // datapath: the entry array shifts as a whole for front insert and
    // for remove, so every request updates the array and result register at the edge it is accepted
    ils_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_resp  (o_resp)
    );

endmodule

`default_nettype wire
